@@ rtl/dps_pkg.sv @@
`timescale 1ns / 1ps

package dps_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [4:0] WORD_BITS_LEFT = 5'd15;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SEND = 2'd1,
    OP_FALL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_SENT = 2'd1,
    ST_DUP  = 2'd2,
    ST_BUSY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_LAST
  } state_e;

  typedef struct packed {
    logic             active;
    logic             dup;
    logic             have_free;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      best_age;
    logic [IDX_W-1:0] best_idx;
  } token_t;

  typedef struct packed {
    logic [7:0]  param;
    logic [7:0]  value;
    logic [31:0] now;
    logic [15:0] timeout;
  } ctx_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       param;
    logic [7:0]       value;
    logic [31:0]      stamp;
  } wr_t;

endpackage

@@ rtl/dps_cell.sv @@
`timescale 1ns / 1ps

module dps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dps_pkg::ctx_t   ctx_i,
  input  dps_pkg::wr_t    wr_i,
  input  dps_pkg::token_t tok_i,
  output dps_pkg::token_t tok_o
);

  localparam logic [dps_pkg::IDX_W-1:0] MyIdx = dps_pkg::IDX_W'(CELL_IDX);
  localparam bit IsFirst = (CELL_IDX == 0);

  logic            valid_q, valid_d;
  logic [7:0]      param_q;
  logic [7:0]      value_q;
  logic [31:0]     stamp_q;
  dps_pkg::token_t tok_q, tok_d;
  logic [31:0]     age;
  logic            expired;
  logic            live;
  logic            hit;
  logic            wr_hit;

  always_comb begin
    age     = ctx_i.now - stamp_q;
    expired = valid_q && (age > {16'b0, ctx_i.timeout});
    live    = valid_q && !expired;
    hit     = live && (param_q == ctx_i.param) && (value_q == ctx_i.value);
    wr_hit  = wr_i.en && (wr_i.idx == MyIdx);

    tok_d = tok_i;
    if (tok_i.active) begin
      if (hit) begin
        tok_d.dup = 1'b1;
      end
      if (!live && !tok_i.have_free) begin
        tok_d.have_free = 1'b1;
        tok_d.free_idx  = MyIdx;
      end
      if (live && (IsFirst || (age > tok_i.best_age))) begin
        tok_d.best_age = age;
        tok_d.best_idx = MyIdx;
      end
    end

    valid_d = valid_q;
    if (tok_i.active && expired) begin
      valid_d = 1'b0;
    end
    if (wr_hit) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      param_q <= wr_i.param;
      value_q <= wr_i.value;
      stamp_q <= wr_i.stamp;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ rtl/dedup_parameter_serializer_top.sv @@
`timescale 1ns / 1ps
// A tick or a partner clock fall gives its result in the cycle after it is taken.
// The clock fall that drives bit 0 gives a second result in the cycle after the first.
// A send walks the row of table cells, one cell a cycle, and busy stays high until its result
// appears. The receiver cannot stall results.
// Reset clears the table valid bits, the serializer and the timer; timeout_ms resets to 100.

module dedup_parameter_serializer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  param_id_i,
  input  logic [7:0]  param_value_i,
  output logic        result_valid_o,
  output logic        data_line_o,
  output logic        ready_line_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  dps_pkg::state_e state_q, state_d;
  logic [15:0]     timeout_q;
  logic [31:0]     now_q, now_d;
  logic [15:0]     shift_q, shift_d;
  logic [4:0]      bits_q, bits_d;
  logic            data_q, data_d;
  logic            ready_q, ready_d;
  logic            launch_q, launch_d;
  logic [7:0]      id_q;
  logic [7:0]      val_q;
  logic            rv_q, rv_d;
  logic            rdata_q, rdata_d;
  logic            rready_q, rready_d;
  logic [1:0]      rstat_q, rstat_d;
  logic            rlast_q, rlast_d;
  logic [4:0]      bits_dec;
  logic [3:0]      bit_idx;
  dps_pkg::ctx_t   ctx;
  dps_pkg::wr_t    wr;
  dps_pkg::token_t tok [dps_pkg::TABLE_DEPTH+1];
  dps_pkg::token_t tok_last;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'b0 : {16'b0, timeout_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= dps_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      timeout_q <= pwdata[15:0];
    end
  end

  assign ctx = '{param: id_q, value: val_q, now: now_q, timeout: timeout_q};

  always_comb begin
    tok[0] = '0;
    tok[0].active = launch_q;
  end

  for (genvar g = 0; g < dps_pkg::TABLE_DEPTH; g++) begin : g_cell
    dps_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctx_i (ctx),
      .wr_i  (wr),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  assign tok_last = tok[dps_pkg::TABLE_DEPTH];
  assign busy     = (state_q != dps_pkg::S_IDLE);
  assign bits_dec = bits_q - 5'd1;
  assign bit_idx  = bits_dec[3:0];

  always_comb begin
    state_d  = state_q;
    now_d    = now_q;
    shift_d  = shift_q;
    bits_d   = bits_q;
    data_d   = data_q;
    ready_d  = ready_q;
    launch_d = 1'b0;
    rv_d     = 1'b0;
    rdata_d  = rdata_q;
    rready_d = rready_q;
    rstat_d  = dps_pkg::ST_NONE;
    rlast_d  = 1'b1;
    wr       = '0;
    wr.param = id_q;
    wr.value = val_q;
    wr.stamp = now_q;

    case (state_q)
      dps_pkg::S_IDLE: begin
        if (start) begin
          rv_d = 1'b1;
          case (dps_pkg::op_e'(operation_i))
            dps_pkg::OP_TICK: begin
              now_d = now_q + 32'd1;
            end
            dps_pkg::OP_SEND: begin
              rv_d     = 1'b0;
              launch_d = 1'b1;
              state_d  = dps_pkg::S_SWEEP;
            end
            dps_pkg::OP_FALL: begin
              if (bits_q != 5'd0) begin
                data_d = ~shift_q[bit_idx];
                bits_d = bits_dec;
                if (bits_dec == 5'd0) begin
                  rlast_d = 1'b0;
                  state_d = dps_pkg::S_LAST;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      dps_pkg::S_SWEEP: begin
        if (tok_last.active) begin
          rv_d    = 1'b1;
          state_d = dps_pkg::S_IDLE;
          if (tok_last.dup) begin
            rstat_d = dps_pkg::ST_DUP;
          end else begin
            wr.en  = 1'b1;
            wr.idx = tok_last.have_free ? tok_last.free_idx : tok_last.best_idx;
            if (bits_q != 5'd0) begin
              rstat_d = dps_pkg::ST_BUSY;
            end else begin
              rstat_d = dps_pkg::ST_SENT;
              shift_d = {id_q, val_q};
              data_d  = ~id_q[7];
              bits_d  = dps_pkg::WORD_BITS_LEFT;
              ready_d = 1'b1;
            end
          end
        end
      end
      dps_pkg::S_LAST: begin
        rv_d    = 1'b1;
        data_d  = 1'b0;
        ready_d = 1'b0;
        state_d = dps_pkg::S_IDLE;
      end
      default: begin
        state_d = dps_pkg::S_IDLE;
      end
    endcase

    rdata_d  = data_d;
    rready_d = ready_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dps_pkg::S_IDLE;
      now_q    <= 32'd0;
      shift_q  <= 16'd0;
      bits_q   <= 5'd0;
      data_q   <= 1'b0;
      ready_q  <= 1'b0;
      launch_q <= 1'b0;
      rv_q     <= 1'b0;
      rdata_q  <= 1'b0;
      rready_q <= 1'b0;
      rstat_q  <= dps_pkg::ST_NONE;
      rlast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      shift_q  <= shift_d;
      bits_q   <= bits_d;
      data_q   <= data_d;
      ready_q  <= ready_d;
      launch_q <= launch_d;
      rv_q     <= rv_d;
      rdata_q  <= rdata_d;
      rready_q <= rready_d;
      rstat_q  <= rstat_d;
      rlast_q  <= rlast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dps_pkg::S_IDLE && start) begin
      id_q  <= param_id_i;
      val_q <= param_value_i;
    end
  end

  assign result_valid_o = rv_q;
  assign data_line_o    = rdata_q;
  assign ready_line_o   = rready_q;
  assign status_o       = rstat_q;
  assign last_o         = rlast_q;

  a_sent_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == dps_pkg::ST_SENT) |-> ready_line_o)
    else $error("send started without ready high");

  a_last_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dps_pkg::S_LAST) |=> (result_valid_o && last_o && !ready_line_o && !data_line_o))
    else $error("final bit not followed by line release");

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= dps_pkg::WORD_BITS_LEFT)
    else $error("bit counter out of range");

  a_token_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last.active |-> (state_q == dps_pkg::S_SWEEP))
    else $error("table token outside a send request");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_DEPTH = dps_pkg::TABLE_DEPTH;
  localparam int POOL_SIZE = 24;
  localparam logic [2:0] ADDR_TIMEOUT = 3'd0;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] id;
    logic [7:0] val;
  } request_t;

  typedef struct packed {
    logic             data;
    logic             ready;
    dps_pkg::status_e status;
    logic             last;
  } line_levels_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = dps_pkg::OP_TICK;
  logic [7:0]  param_id_i = '0;
  logic [7:0]  param_value_i = '0;
  logic        result_valid_o;
  logic        data_line_o;
  logic        ready_line_o;
  logic [1:0]  status_o;
  logic        last_o;

  dedup_parameter_serializer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .param_id_i    (param_id_i),
    .param_value_i (param_value_i),
    .result_valid_o(result_valid_o),
    .data_line_o   (data_line_o),
    .ready_line_o  (ready_line_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  // Shadow copy of the serializer and its table of recently recorded pairs.
  logic [15:0] timeout_ms_cfg = dps_pkg::TIMEOUT_RESET;
  logic [31:0] now_ms = '0;
  bit          pair_vld [TABLE_DEPTH];
  logic [7:0]  pair_id [TABLE_DEPTH];
  logic [7:0]  pair_val [TABLE_DEPTH];
  logic [31:0] pair_stamp [TABLE_DEPTH];
  logic [15:0] shift_word = '0;
  logic [4:0]  bits_left = '0;
  logic        data_level = 1'b0;
  logic        ready_level = 1'b0;

  request_t     request_queue [$];
  line_levels_t line_levels_due [$];
  request_t     drv_req;
  logic [15:0]  pair_pool [POOL_SIZE];
  int           queued_cnt = 0;
  int           accepted_cnt = 0;
  int           gap_left = 0;
  bit           no_gap = 1'b0;
  int           fail_cnt = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void note_mismatch(input string msg);
    if (fail_cnt < 10) $display("%s", msg);
    fail_cnt++;
  endfunction

  function automatic void expect_levels(input dps_pkg::status_e st, input logic last);
    line_levels_t lv;
    lv = '{data_level, ready_level, st, last};
    line_levels_due.insert(line_levels_due.size(), lv);
  endfunction

  function automatic dps_pkg::status_e record_pair(input logic [7:0] id,
                                                   input logic [7:0] val);
    int          slot;
    int          best;
    bit          have_free;
    logic [31:0] best_age;
    logic [31:0] age;
    slot = 0;
    best = 0;
    have_free = 1'b0;
    best_age = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      age = now_ms - pair_stamp[i];
      if (pair_vld[i] && age > {16'd0, timeout_ms_cfg}) pair_vld[i] = 1'b0;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (pair_vld[i] && pair_id[i] == id && pair_val[i] == val) return dps_pkg::ST_DUP;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!pair_vld[i]) begin
        if (!have_free) begin
          have_free = 1'b1;
          slot = i;
        end
      end else begin
        age = now_ms - pair_stamp[i];
        if (i == 0 || age > best_age) begin
          best_age = age;
          best = i;
        end
      end
    end
    if (!have_free) slot = best;
    pair_vld[slot] = 1'b1;
    pair_id[slot] = id;
    pair_val[slot] = val;
    pair_stamp[slot] = now_ms;
    if (bits_left != 0) return dps_pkg::ST_BUSY;
    shift_word = {id, val};
    data_level = ~id[7];
    bits_left = dps_pkg::WORD_BITS_LEFT;
    ready_level = 1'b1;
    return dps_pkg::ST_SENT;
  endfunction

  function automatic void predict_line_levels(input request_t req);
    dps_pkg::status_e st;
    if (req.op == dps_pkg::OP_TICK) begin
      now_ms = now_ms + 1;
      expect_levels(dps_pkg::ST_NONE, 1'b1);
    end else if (req.op == dps_pkg::OP_SEND) begin
      st = record_pair(req.id, req.val);
      expect_levels(st, 1'b1);
    end else if (req.op == dps_pkg::OP_FALL && bits_left != 0) begin
      bits_left = bits_left - 1;
      data_level = ~shift_word[bits_left[3:0]];
      if (bits_left == 0) begin
        expect_levels(dps_pkg::ST_NONE, 1'b0);
        ready_level = 1'b0;
        data_level = 1'b0;
      end
      expect_levels(dps_pkg::ST_NONE, 1'b1);
    end else begin
      expect_levels(dps_pkg::ST_NONE, 1'b1);
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        predict_line_levels(drv_req);
        accepted_cnt++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_queue.size() > 0) begin
        drv_req = request_queue.pop_front();
        operation_i <= drv_req.op;
        param_id_i <= drv_req.id;
        param_value_i <= drv_req.val;
        start <= 1'b1;
        if ($urandom_range(0, 39) == 0) no_gap = !no_gap;
        gap_left = no_gap ? 0 : $urandom_range(0, 18);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    line_levels_t want;
    if (rst_ni && result_valid_o) begin
      if (line_levels_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result: data=%0b ready=%0b status=%0d last=%0b",
                                data_line_o, ready_line_o, status_o, last_o));
      end else begin
        want = line_levels_due.pop_front();
        if (data_line_o !== want.data || ready_line_o !== want.ready ||
            status_o !== want.status || last_o !== want.last) begin
          note_mismatch($sformatf({"result mismatch: expected data=%0b ready=%0b status=%0d ",
                                   "last=%0b, got data=%0b ready=%0b status=%0d last=%0b"},
            want.data, want.ready, want.status, want.last,
            data_line_o, ready_line_o, status_o, last_o));
        end
      end
    end
  end

  task automatic timeout_access(input bit wr, input logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_TIMEOUT;
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (wr) begin
      timeout_ms_cfg = value;
    end else if (prdata[15:0] !== value) begin
      note_mismatch($sformatf("timeout readback: expected %0d, got %0d", value, prdata[15:0]));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void queue_request(input logic [1:0] op, input logic [7:0] id,
                                        input logic [7:0] val);
    request_t req;
    req = '{op, id, val};
    request_queue.insert(request_queue.size(), req);
    queued_cnt++;
  endfunction

  function automatic logic [15:0] draw_pair();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return pair_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic drain();
    @(posedge clk_i);
    while (accepted_cnt != queued_cnt || line_levels_due.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [15:0] timeout, input int quota);
    int          made;
    int          n;
    int          burst_max;
    logic [15:0] pair;
    timeout_access(1'b1, timeout);
    timeout_access(1'b0, timeout);
    foreach (pair_pool[i]) pair_pool[i] = 16'($urandom);
    burst_max = (timeout < 30) ? timeout + 3 : 10;
    made = 0;
    while (made < quota) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          pair = draw_pair();
          queue_request(dps_pkg::OP_SEND, pair[15:8], pair[7:0]);
          made++;
          for (int k = 0; k < dps_pkg::WORD_BITS_LEFT; k++) begin
            if ($urandom_range(0, 3) == 0) begin
              n = $urandom_range(1, 2);
              repeat (n) queue_request(dps_pkg::OP_TICK, 8'($urandom), 8'($urandom));
              made += n;
            end
            if ($urandom_range(0, 7) == 0) begin
              pair = draw_pair();
              queue_request(dps_pkg::OP_SEND, pair[15:8], pair[7:0]);
              made++;
            end
            queue_request(dps_pkg::OP_FALL, 8'($urandom), 8'($urandom));
            made++;
          end
        end
        5, 6: begin
          n = $urandom_range(1, burst_max);
          repeat (n) queue_request(dps_pkg::OP_TICK, 8'($urandom), 8'($urandom));
          made += n;
        end
        7, 8: begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            pair = draw_pair();
            queue_request(dps_pkg::OP_SEND, pair[15:8], pair[7:0]);
          end
          made += n;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
              queue_request(2'($urandom), 8'($urandom), 8'($urandom));
            end
            made += n;
          end else begin
            pair = draw_pair();
            queue_request(dps_pkg::OP_SEND, pair[15:8], pair[7:0]);
            n = $urandom_range(1, 14);
            repeat (n) queue_request(dps_pkg::OP_FALL, 8'($urandom), 8'($urandom));
            made += n + 1;
          end
        end
      endcase
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    timeout_access(1'b0, dps_pkg::TIMEOUT_RESET);

    queue_request(dps_pkg::OP_FALL, 8'hFF, 8'hFF);
    queue_request(OP_UNUSED, 8'h00, 8'h00);
    queue_request(dps_pkg::OP_TICK, 8'hAA, 8'h55);
    queue_request(dps_pkg::OP_SEND, 8'hFF, 8'h00);
    queue_request(dps_pkg::OP_SEND, 8'hFF, 8'h00);
    queue_request(dps_pkg::OP_SEND, 8'h00, 8'hFF);
    for (int k = 0; k <= dps_pkg::WORD_BITS_LEFT; k++) begin
      queue_request(dps_pkg::OP_FALL, 8'h00, 8'h00);
    end
    drain();

    random_phase(16'd0, 300);
    random_phase(16'hFFFF, 300);
    random_phase(16'd1, 300);
    random_phase(16'($urandom_range(2, 12)), 300);
    random_phase(16'($urandom_range(13, 40)), 300);
    random_phase(dps_pkg::TIMEOUT_RESET, 300);

    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
